// ----- rtl/core/fat_chain_next_cluster_macros.svh -----
// Assertion macros shared by the checker of the FAT next-cluster block.
`ifndef FAT_CHAIN_NEXT_CLUSTER_MACROS_SVH
`define FAT_CHAIN_NEXT_CLUSTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCNC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcnc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcnc check failed");

`endif

// ----- rtl/core/fcnc_pkg.sv -----
// Types, codes and constants of the FAT next-cluster block.
`default_nettype none

package fcnc_pkg;

  // Sizes and markers.
  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CFG_W       = 31;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [31:0] END_MARK  = 32'hFFFF_FFFF;
  localparam logic [31:0] NEXT_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] ALLOC_BIT = 32'h8000_0000;

  // Input item kinds.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_READ  = 2'd0;
  localparam logic [1:0] RES_NEXT  = 2'd1;
  localparam logic [1:0] RES_END   = 2'd2;
  localparam logic [1:0] RES_ERROR = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RANGE    = 3'd1;
  localparam logic [2:0] ERR_DOUBLE   = 3'd2;
  localparam logic [2:0] ERR_IND      = 3'd3;
  localparam logic [2:0] ERR_FAT      = 3'd4;
  localparam logic [2:0] ERR_UNALLOC  = 3'd5;
  localparam logic [2:0] ERR_NEXT_BAD = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC    = 2'd2;

  // Input beat payload.
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [31:0] cluster;
    logic [31:0] mem_word;
  } in_item_t;

  // Output beat payload.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] page;
    logic [6:0]  word_index;
    logic [30:0] next_link;
    logic [2:0]  error_code;
  } out_item_t;

  // Source of the page address in a read request.
  typedef enum logic {
    PG_REQ,
    PG_FAT
  } pg_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       tbl_we;
    logic       pend_load;
    logic       out_load;
    logic [1:0] out_kind;
    logic [2:0] out_err;
    pg_sel_e    page_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] req_err;
    logic       ind_bad;
    logic       fat_end;
    logic       fat_unalloc;
    logic       fat_next_bad;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/fcnc_datapath.sv -----
// Datapath: input register, configuration, indirect table, checks and output register.
`default_nettype none

module fcnc_datapath
  import fcnc_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire in_item_t        in_item_i,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]      cfg_data_i,
  input  wire dp_cmd_t         cmd_i,
  output dp_status_t           status_o,
  output out_item_t            out_item_o
);

  in_item_t    item_q;
  logic [1:0]  pages_q;
  logic [30:0] cpc_q;
  logic [30:0] alloc_q;
  logic [31:0] tbl_q [TABLE_SLOTS];
  logic [31:0] pending_q;
  logic [7:0]  eo_q;
  out_item_t   out_q;

  logic        ppc2;
  logic [31:0] ii;
  logic [31:0] di;
  logic [7:0]  io;
  logic        di_big;
  logic [31:0] ic;
  logic [7:0]  eo_d;
  logic [31:0] req_base;
  logic [31:0] req_page;
  logic [31:0] fat_base;
  logic [31:0] fat_page;
  logic [30:0] nx;
  out_item_t   out_d;

  // Capture the accepted input beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= 2'd2;
      cpc_q   <= 31'd8192;
      alloc_q <= 31'd8135;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGES:    pages_q <= cfg_data_i[1:0];
        CFG_CLUSTERS: cpc_q   <= cfg_data_i;
        CFG_ALLOC:    alloc_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Any value other than one gives two pages per cluster.
  assign ppc2 = (pages_q != 2'd1);

  // Split the relative cluster into indirect index, offset and double index.
  always_comb begin
    ii     = ppc2 ? (item_q.cluster >> 8) : (item_q.cluster >> 7);
    di     = ppc2 ? (item_q.cluster >> 16) : (item_q.cluster >> 14);
    io     = ppc2 ? ii[7:0] : {1'b0, ii[6:0]};
    eo_d   = ppc2 ? item_q.cluster[7:0] : {1'b0, item_q.cluster[6:0]};
    di_big = (di >= 32'(TABLE_SLOTS));
    ic     = tbl_q[di[SLOT_W-1:0]];
  end

  // Page addresses of the indirect word and of the FAT word.
  always_comb begin
    req_base = ppc2 ? {ic[30:0], 1'b0} : ic;
    req_page = req_base + {31'd0, io[7]};
    fat_base = ppc2 ? {item_q.mem_word[30:0], 1'b0} : item_q.mem_word;
    fat_page = fat_base + {31'd0, eo_q[7]};
    nx       = item_q.mem_word[30:0];
  end

  // Check results for the controller.
  always_comb begin
    status_o.kind = item_q.kind;
    if (item_q.cluster >= {1'b0, alloc_q}) begin
      status_o.req_err = ERR_RANGE;
    end else if (di_big) begin
      status_o.req_err = ERR_DOUBLE;
    end else if (ic == END_MARK || ic >= {1'b0, cpc_q}) begin
      status_o.req_err = ERR_IND;
    end else begin
      status_o.req_err = ERR_NONE;
    end
    status_o.ind_bad      = (item_q.mem_word == END_MARK) ||
                            (item_q.mem_word >= {1'b0, cpc_q});
    status_o.fat_end      = (item_q.mem_word == END_MARK);
    status_o.fat_unalloc  = ((item_q.mem_word & ALLOC_BIT) == 32'd0);
    status_o.fat_next_bad = !((nx < alloc_q) && ({1'b0, nx} != pending_q));
  end

  // Indirect table; slots reset to the end marker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        tbl_q[i] <= END_MARK;
      end
    end else if (cmd_i.tbl_we && ({27'd0, item_q.slot} < 32'(TABLE_SLOTS))) begin
      tbl_q[SLOT_W'(item_q.slot)] <= item_q.cluster;
    end
  end

  // Request in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 32'd0;
      eo_q      <= 8'd0;
    end else if (cmd_i.pend_load) begin
      pending_q <= item_q.cluster;
      eo_q      <= eo_d;
    end
  end

  // Build the result beat; unused fields are zero.
  always_comb begin
    out_d              = '0;
    out_d.result_kind  = cmd_i.out_kind;
    out_d.error_code   = cmd_i.out_err;
    if (cmd_i.out_kind == RES_READ) begin
      if (cmd_i.page_sel == PG_REQ) begin
        out_d.page       = req_page;
        out_d.word_index = io[6:0];
      end else begin
        out_d.page       = fat_page;
        out_d.word_index = eo_q[6:0];
      end
    end
    if (cmd_i.out_kind == RES_NEXT) begin
      out_d.next_link = nx;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/fcnc_ctrl.sv -----
// Controller: beat handshake, chain phase and result decisions.
`default_nettype none

module fcnc_ctrl
  import fcnc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t     cmd_o
);

  typedef enum logic {
    ST_READY,
    ST_EXEC
  } st_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_IND,
    PH_WAIT_FAT
  } phase_e;

  st_e    state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  logic   res_valid;
  logic   out_free;
  logic   fire;
  dp_cmd_t dec;

  // The output register can take a beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Decide what the registered item does.
  always_comb begin
    dec          = '0;
    dec.out_kind = RES_READ;
    dec.out_err  = ERR_NONE;
    dec.page_sel = PG_REQ;
    res_valid    = 1'b0;
    phase_d      = phase_q;
    case (status_i.kind)
      KIND_LOAD: begin
        dec.tbl_we = 1'b1;
      end
      KIND_REQ: begin
        res_valid = 1'b1;
        if (status_i.req_err != ERR_NONE) begin
          dec.out_kind = RES_ERROR;
          dec.out_err  = status_i.req_err;
          phase_d      = PH_IDLE;
        end else begin
          dec.pend_load = 1'b1;
          phase_d       = PH_WAIT_IND;
        end
      end
      KIND_RESP: begin
        case (phase_q)
          PH_WAIT_IND: begin
            res_valid = 1'b1;
            if (status_i.ind_bad) begin
              dec.out_kind = RES_ERROR;
              dec.out_err  = ERR_FAT;
              phase_d      = PH_IDLE;
            end else begin
              dec.page_sel = PG_FAT;
              phase_d      = PH_WAIT_FAT;
            end
          end
          PH_WAIT_FAT: begin
            res_valid = 1'b1;
            phase_d   = PH_IDLE;
            if (status_i.fat_end) begin
              dec.out_kind = RES_END;
            end else if (status_i.fat_unalloc) begin
              dec.out_kind = RES_ERROR;
              dec.out_err  = ERR_UNALLOC;
            end else if (status_i.fat_next_bad) begin
              dec.out_kind = RES_ERROR;
              dec.out_err  = ERR_NEXT_BAD;
            end else begin
              dec.out_kind = RES_NEXT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // The item completes once its result, if any, has a place to go.
  assign fire = (state_q == ST_EXEC) && (!res_valid || out_free);

  // Commands to the datapath.
  always_comb begin
    cmd_o           = dec;
    cmd_o.capture   = (state_q == ST_READY) && in_valid_i;
    cmd_o.tbl_we    = fire && dec.tbl_we;
    cmd_o.pend_load = fire && dec.pend_load;
    cmd_o.out_load  = fire && res_valid;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_READY: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:  if (fire) state_d = ST_READY;
      default:  state_d = ST_READY;
    endcase
    if (fire && res_valid) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  // State, chain phase and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q <= phase_d;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_READY);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/fat_chain_next_cluster.sv -----
// Top level of the FAT chain next-cluster resolver.
//
//   channel   direction  handshake            payload
//   in        input      in_valid_i/in_stall_o  in_item_t
//   out       output     out_valid_o/out_stall_i out_item_t
//   cfg       input      cfg_we_i             cfg_idx_i, cfg_data_i
//
// An item is first registered in ST_READY; in ST_EXEC the controller then evaluates
// it against the indirect table and writes the output register.
// ST_EXEC holds while a result is due and the output beat is stalled.
// A new input beat is taken while a finished result still waits at the output.
// Reset sets every table slot to the end marker at once; there is no clearing pass.
`default_nettype none

module fat_chain_next_cluster
  import fcnc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire in_item_t       in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output out_item_t           out_item_o,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]     cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing and decisions.
  fcnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Storage and arithmetic.
  fcnc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/fcnc_checker.sv -----
// Port-level checker of the FAT next-cluster block and its bind.
`default_nettype none
`include "fat_chain_next_cluster_macros.svh"

module fcnc_checker
  import fcnc_pkg::*;
(
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire out_item_t      out_item_o
);

  logic out_waiting;
  logic not_read;
  logic addr_clear;
  logic code_fits;

  // Conditions on the output beat.
  assign out_waiting = out_valid_o && out_stall_i;
  assign not_read    = (out_item_o.result_kind != RES_READ);
  assign addr_clear  = (out_item_o.page == 32'd0) && (out_item_o.word_index == 7'd0);

  // An error beat carries a known code; any other beat carries none.
  assign code_fits = (out_item_o.result_kind == RES_ERROR) ?
                     (out_item_o.error_code != ERR_NONE &&
                      out_item_o.error_code <= ERR_NEXT_BAD) :
                     (out_item_o.error_code == ERR_NONE);

  // A stalled output beat holds.
  `FCNC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_waiting, out_valid_o && $stable(out_item_o))

  // An accepted input beat keeps the block busy in the next cycle.
  `FCNC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Only read requests carry an address.
  `FCNC_ASSERT_NOW(a_addr_zero, clk_i, rst_ni, out_valid_o && not_read, addr_clear)

  // Error results carry a known code; others carry none.
  `FCNC_ASSERT_NOW(a_err_code, clk_i, rst_ni, out_valid_o, code_fits)

endmodule

bind fat_chain_next_cluster fcnc_checker u_fcnc_checker (.*);

`default_nettype wire
